FILE: hw/rtl/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared constants, types and the control program of the DFS path search unit.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int VERTICES    = 16;
  localparam int VTX_W       = $clog2(VERTICES);
  localparam int STACK_SLOTS = 16;
  localparam int SADDR_W     = $clog2(STACK_SLOTS);
  localparam int DEPTH_W     = SADDR_W + 1;
  localparam int STEP_W      = 4;

  // Program step addresses
  localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] S_INIT     = 4'd1;
  localparam logic [STEP_W-1:0] S_TEST     = 4'd2;
  localparam logic [STEP_W-1:0] S_CAND     = 4'd3;
  localparam logic [STEP_W-1:0] S_PUSH     = 4'd4;
  localparam logic [STEP_W-1:0] S_POPCHK   = 4'd5;
  localparam logic [STEP_W-1:0] S_POPRD    = 4'd6;
  localparam logic [STEP_W-1:0] S_POPLD    = 4'd7;
  localparam logic [STEP_W-1:0] S_NOTFOUND = 4'd8;
  localparam logic [STEP_W-1:0] S_DONE     = 4'd9;
  localparam logic [STEP_W-1:0] S_PSET     = 4'd10;
  localparam logic [STEP_W-1:0] S_PRD      = 4'd11;
  localparam logic [STEP_W-1:0] S_PEM      = 4'd12;
  localparam logic [STEP_W-1:0] S_PCHK     = 4'd13;
  localparam logic [STEP_W-1:0] S_FSTART   = 4'd14;
  localparam logic [STEP_W-1:0] S_DONE2    = 4'd15;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,     // take a beat; edge writes complete here
    OP_INIT,       // seed visited mask and stack with the start vertex
    OP_PUSH,       // enter lowest unvisited neighbour
    OP_POP,        // drop top, read new top from stack
    OP_LOAD_TOP,   // capture stack read data as top
    OP_EMIT_FAIL,  // emit start vertex, found clear
    OP_SET_IDX,    // path index = depth - 1
    OP_READ_IDX,   // read stack at path index
    OP_EMIT_PATH,  // emit stack read data, step index down
    OP_EMIT_FOUND  // emit start vertex, found set
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_QUERY,
    C_START_IS_END,
    C_TOP_IS_END,
    C_CAND_EMPTY,
    C_DEPTH_ONE,
    C_OUT_BUSY,
    C_IDX_NONZERO
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic query_in;
    logic start_is_end;
    logic top_is_end;
    logic cand_empty;
    logic depth_one;
    logic out_busy;
    logic idx_nonzero;
  } dp_status_t;

  // Control store: on a true condition jump to target, else fall through
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
    unique case (step)
      S_IDLE:     w = '{op: OP_ACCEPT,     cond: C_NO_QUERY,     target: S_IDLE};
      S_INIT:     w = '{op: OP_INIT,       cond: C_START_IS_END, target: S_FSTART};
      S_TEST:     w = '{op: OP_NONE,       cond: C_TOP_IS_END,   target: S_PSET};
      S_CAND:     w = '{op: OP_NONE,       cond: C_CAND_EMPTY,   target: S_POPCHK};
      S_PUSH:     w = '{op: OP_PUSH,       cond: C_ALWAYS,       target: S_TEST};
      S_POPCHK:   w = '{op: OP_NONE,       cond: C_DEPTH_ONE,    target: S_NOTFOUND};
      S_POPRD:    w = '{op: OP_POP,        cond: C_NEVER,        target: S_IDLE};
      S_POPLD:    w = '{op: OP_LOAD_TOP,   cond: C_ALWAYS,       target: S_TEST};
      S_NOTFOUND: w = '{op: OP_EMIT_FAIL,  cond: C_OUT_BUSY,     target: S_NOTFOUND};
      S_DONE:     w = '{op: OP_NONE,       cond: C_ALWAYS,       target: S_IDLE};
      S_PSET:     w = '{op: OP_SET_IDX,    cond: C_NEVER,        target: S_IDLE};
      S_PRD:      w = '{op: OP_READ_IDX,   cond: C_NEVER,        target: S_IDLE};
      S_PEM:      w = '{op: OP_EMIT_PATH,  cond: C_OUT_BUSY,     target: S_PEM};
      S_PCHK:     w = '{op: OP_NONE,       cond: C_IDX_NONZERO,  target: S_PRD};
      S_FSTART:   w = '{op: OP_EMIT_FOUND, cond: C_OUT_BUSY,     target: S_FSTART};
      S_DONE2:    w = '{op: OP_NONE,       cond: C_ALWAYS,       target: S_IDLE};
      default:    w = '{op: OP_NONE,       cond: C_ALWAYS,       target: S_IDLE};
    endcase
    return w;
  endfunction

  // Index of the lowest set bit
  function automatic logic [VTX_W-1:0] lowest_set(input logic [VERTICES-1:0] m);
    logic [VTX_W-1:0] r;
    r = '0;
    for (int i = VERTICES - 1; i >= 0; i--) begin
      if (m[i]) r = VTX_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/gdfs_seq.sv
// ----------------------------------------------------------------------------
// gdfs_seq
// Step counter and control store; evaluates jump conditions from the datapath.
// ----------------------------------------------------------------------------
module gdfs_seq import gdfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output ctrl_word_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  assign ctrl = ucode_rom(step);

  // Condition select
  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_QUERY:     take = !status.query_in;
      C_START_IS_END: take = status.start_is_end;
      C_TOP_IS_END:   take = status.top_is_end;
      C_CAND_EMPTY:   take = status.cand_empty;
      C_DEPTH_ONE:    take = status.depth_one;
      C_OUT_BUSY:     take = status.out_busy;
      C_IDX_NONZERO:  take = status.idx_nonzero;
      default:        take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // A search only starts from idle at the init step
  a_idle_exit: assert property (@(posedge clk) disable iff (rst)
    (step == S_IDLE) |=> (step == S_IDLE || step == S_INIT))
    else $error("idle left to a step other than init");

  // Waiting on the result channel never moves the program
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (ctrl.cond == C_OUT_BUSY && status.out_busy) |=> $stable(step))
    else $error("step moved while result register busy");

  // Only a query beat starts a search
  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (step == S_IDLE && !status.query_in) |=> (step == S_IDLE))
    else $error("search started without a query beat");

endmodule

FILE: hw/rtl/gdfs_stack_ram.sv
// ----------------------------------------------------------------------------
// gdfs_stack_ram
// Search path stack: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gdfs_stack_ram import gdfs_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [SADDR_W-1:0] wr_addr,
  input  logic [VTX_W-1:0]   wr_data,
  input  logic               rd_en,
  input  logic [SADDR_W-1:0] rd_addr,
  output logic [VTX_W-1:0]   rd_data
);

  logic [VTX_W-1:0] mem [STACK_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/gdfs_datapath.sv
// ----------------------------------------------------------------------------
// gdfs_datapath
// Adjacency rows, visited mask, stack pointer, path index and result register.
// ----------------------------------------------------------------------------
module gdfs_datapath import gdfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_word_t        ctrl,
  output dp_status_t        status,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic              req_type,
  input  logic [VTX_W-1:0]  vertex_a,
  input  logic [VTX_W-1:0]  vertex_b,
  input  logic              edge_present,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [VTX_W-1:0]  path_vertex,
  output logic              found,
  output logic              last
);

  logic [VERTICES-1:0] adj [VERTICES];
  logic [VERTICES-1:0] visited;
  logic [DEPTH_W-1:0]  depth;
  logic [VTX_W-1:0]    top;
  logic [VTX_W-1:0]    start_v;
  logic [VTX_W-1:0]    end_v;
  logic [SADDR_W-1:0]  idx;

  logic                beat;
  logic                out_free;
  logic                emit;
  logic [VERTICES-1:0] cand;
  logic [VTX_W-1:0]    next_v;

  logic                st_wr_en;
  logic [SADDR_W-1:0]  st_wr_addr;
  logic [VTX_W-1:0]    st_wr_data;
  logic                st_rd_en;
  logic [SADDR_W-1:0]  st_rd_addr;
  logic [VTX_W-1:0]    st_rd_data;

  // Input handshake: beats only taken at the idle step
  assign req_stall = (ctrl.op != OP_ACCEPT);
  assign beat      = req_valid && !req_stall;

  // Result register frees when empty or being drained
  assign out_free = !res_valid || !res_stall;
  assign emit     = out_free && (ctrl.op == OP_EMIT_FAIL || ctrl.op == OP_EMIT_PATH ||
                                 ctrl.op == OP_EMIT_FOUND);

  // Neighbour pick
  assign cand   = adj[top] & ~visited;
  assign next_v = lowest_set(cand);

  // Status back to the sequencer
  always_comb begin
    status.query_in     = beat && req_type;
    status.start_is_end = (start_v == end_v);
    status.top_is_end   = (top == end_v);
    status.cand_empty   = (cand == '0) || (depth >= DEPTH_W'(STACK_SLOTS));
    status.depth_one    = (depth == DEPTH_W'(1));
    status.out_busy     = !out_free;
    status.idx_nonzero  = (idx != '0);
  end

  // Stack port control
  always_comb begin
    st_wr_en   = (ctrl.op == OP_INIT) || (ctrl.op == OP_PUSH);
    st_wr_addr = (ctrl.op == OP_INIT) ? '0 : depth[SADDR_W-1:0];
    st_wr_data = (ctrl.op == OP_INIT) ? start_v : next_v;
    st_rd_en   = (ctrl.op == OP_POP) || (ctrl.op == OP_READ_IDX);
    st_rd_addr = (ctrl.op == OP_POP) ? SADDR_W'(depth - DEPTH_W'(2)) : idx;
  end

  gdfs_stack_ram u_stack (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Control state: graph, search state, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < VERTICES; r++) adj[r] <= '0;
      visited   <= '0;
      depth     <= '0;
      res_valid <= 1'b0;
    end else begin
      // Symmetric edge write; a self loop touches a single bit
      if (beat && !req_type) begin
        for (int r = 0; r < VERTICES; r++) begin
          if (VTX_W'(r) == vertex_a) adj[r][vertex_b] <= edge_present;
          else if (VTX_W'(r) == vertex_b) adj[r][vertex_a] <= edge_present;
        end
      end
      unique case (ctrl.op)
        OP_INIT: begin
          visited <= VERTICES'(1) << start_v;
          depth   <= DEPTH_W'(1);
        end
        OP_PUSH: begin
          visited <= visited | (VERTICES'(1) << next_v);
          depth   <= depth + DEPTH_W'(1);
        end
        OP_POP: begin
          depth <= depth - DEPTH_W'(1);
        end
        default: ;
      endcase
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (beat && req_type) begin
      start_v <= vertex_a;
      end_v   <= vertex_b;
    end
    unique case (ctrl.op)
      OP_INIT:     top <= start_v;
      OP_PUSH:     top <= next_v;
      OP_LOAD_TOP: top <= st_rd_data;
      OP_SET_IDX:  idx <= SADDR_W'(depth - DEPTH_W'(1));
      OP_EMIT_PATH: begin
        if (emit) idx <= idx - SADDR_W'(1);
      end
      default: ;
    endcase
    if (emit) begin
      unique case (ctrl.op)
        OP_EMIT_PATH: begin
          path_vertex <= st_rd_data;
          found       <= 1'b0;
          last        <= 1'b0;
        end
        OP_EMIT_FOUND: begin
          path_vertex <= start_v;
          found       <= 1'b1;
          last        <= 1'b1;
        end
        default: begin
          path_vertex <= start_v;
          found       <= 1'b0;
          last        <= 1'b1;
        end
      endcase
    end
  end

  // Stack never grows past its slots
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(STACK_SLOTS))
    else $error("stack depth overflow");

  // Each push marks exactly one new vertex
  a_push_marks: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_PUSH) |=> ($countones(visited) == $past($countones(visited)) + 1))
    else $error("push did not mark a new vertex");

  // The top of a live stack is always visited
  a_top_visited: assert property (@(posedge clk) disable iff (rst)
    (depth != '0) |-> visited[top])
    else $error("top vertex not marked visited");

endmodule

FILE: hw/rtl/graph_dfs_path_search_unit.sv
// ----------------------------------------------------------------------------
// graph_dfs_path_search_unit
// Depth-first path search over a 16-vertex undirected adjacency matrix.
// ----------------------------------------------------------------------------
// An edge-write beat (req_type 0) gives no result. A query beat (req_type 1)
// is followed by an init step and a search run by a 16-step control program:
// each descent to a new vertex runs test, pick and push, each backtrack runs
// test, pick, check, stack read and reload, the stack being a memory with
// registered read data. Once the end vertex is reached, final test and index
// setup run before the path leaves from the end vertex back to the start, each
// beat by stack read, emit and index check, then the closing start-vertex
// beat, each emit waiting while res_stall holds. A query with start equal to
// end, or with no path, gives one beat carrying the start vertex. No new beat
// is taken until the last result beat of a query is in the result register.
// ----------------------------------------------------------------------------
module graph_dfs_path_search_unit import gdfs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic             req_type,
  input  logic [VTX_W-1:0] vertex_a,
  input  logic [VTX_W-1:0] vertex_b,
  input  logic             edge_present,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [VTX_W-1:0] path_vertex,
  output logic             found,
  output logic             last
);

  ctrl_word_t ctrl;
  dp_status_t status;

  gdfs_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  gdfs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .edge_present (edge_present),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .path_vertex  (path_vertex),
    .found        (found),
    .last         (last)
  );

endmodule
